// ===== src/hpma_pkg.sv =====
// ----------------------------------------------------------------------------
// hpma_pkg
// Shared constants and types for the half-period moving average unit.
// ----------------------------------------------------------------------------
package hpma_pkg;

  localparam int unsigned DEPTH = 50;

  // ring index width; one bit minimum so a single-entry ring still has an address
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [15:0] ZERO_CROSS_PIN = 16'h0040;

  // sum / DEPTH as (sum * DIV_MULT) >> (32 + DIV_SHIFT), exact for any 32-bit sum
  localparam int unsigned DIV_SHIFT = $clog2(DEPTH);
  localparam logic [32:0] DIV_MULT  =
    33'(((64'd1 << (32 + DIV_SHIFT)) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    logic [31:0]      data;
  } ring_wr_t;

endpackage

// ===== src/hpma_if.sv =====
// ----------------------------------------------------------------------------
// hpma channel interfaces
// Valid/ready channels for edge events, results and the enable register.
// ----------------------------------------------------------------------------
interface hpma_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pin_mask;
  logic [63:0] timestamp_us;

  modport source (output valid, output pin_mask, output timestamp_us, input ready);
  modport sink   (input valid, input pin_mask, input timestamp_us, output ready);
endinterface

interface hpma_out_if;
  logic        valid;
  logic        ready;
  logic        edge_taken;
  logic [31:0] half_period;
  logic [31:0] average_half_period;
  logic [31:0] edge_total;
  logic        notify;

  modport source (output valid, output edge_taken, output half_period,
                  output average_half_period, output edge_total, output notify,
                  input ready);
  modport sink   (input valid, input edge_taken, input half_period,
                  input average_half_period, input edge_total, input notify,
                  output ready);
endinterface

interface hpma_cfg_if;
  logic valid;
  logic ready;
  logic notify_enable;

  modport source (output valid, output notify_enable, input ready);
  modport sink   (input valid, input notify_enable, output ready);
endinterface

// ===== src/half_period_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// half_period_moving_average_unit
// Zero-crossing edge timing: keeps a ring of recent half periods, a running
// sum and an edge count; reports the duration, window mean, count and notify.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake      | payload
//  in_chan  | in  | valid / ready  | pin_mask[16], timestamp_us[64]
//  out_chan | out | valid / ready  | edge_taken, half_period[32],
//           |     |                | average_half_period[32], edge_total[32], notify
//  cfg_chan | in  | valid / ready  | notify_enable (always ready)
//
//  One event per cycle sustained while out_chan is ready; the result passes
//  stage 2 and stage 3. The update stage reads the old ring entry from a port
//  prefetched at the next ring position, so consecutive edges never wait on the memory.
//  Reset clears the ring's valid bits at once; no clearing pass.
//  A stage holds while the next one is full and stalled; stalls back up in order.
// ----------------------------------------------------------------------------
module half_period_moving_average_unit (
  input  logic       clk,
  input  logic       rst_n,
  hpma_in_if.sink    in_chan,
  hpma_out_if.source out_chan,
  hpma_cfg_if.sink   cfg_chan
);

  localparam int unsigned PW = hpma_pkg::PTR_W;

  logic notify_enable_r;

  // stage 1: input register
  logic        v1_r;
  logic [15:0] mask1_r;
  logic [63:0] stamp1_r;

  // stage 2: updated state snapshot
  logic        v2_r;
  logic        taken2_r;
  logic [31:0] dur2_r;
  logic [31:0] sum2_r;
  logic [31:0] count2_r;
  logic        notify2_r;

  // stage 3: output register
  logic        v3_r;
  logic        taken3_r;
  logic [31:0] dur3_r;
  logic [31:0] avg3_r;
  logic [31:0] count3_r;
  logic        notify3_r;

  // block state
  logic [63:0] prev_stamp_r;
  logic [PW-1:0] pos_r;
  logic [31:0] sum_r;
  logic [31:0] count_r;

  logic ready1, ready2, ready3, mv12;
  logic taken;
  logic [31:0] dur;
  logic [31:0] old_entry;
  logic [31:0] sum_nxt;
  logic [31:0] count_nxt;
  logic [PW-1:0] pos_nxt;
  logic [PW-1:0] pos_inc;
  logic [64:0] prod;
  hpma_pkg::ring_wr_t ring_wr;

  assign ready3 = !v3_r || out_chan.ready;
  assign ready2 = !v2_r || ready3;
  assign ready1 = !v1_r || ready2;
  assign mv12   = v1_r && ready2;

  assign in_chan.ready  = ready1;
  assign cfg_chan.ready = 1'b1;

  assign taken = (mask1_r == hpma_pkg::ZERO_CROSS_PIN);
  assign dur   = stamp1_r[31:0] - prev_stamp_r[31:0];

  assign pos_inc = (pos_r == PW'(hpma_pkg::DEPTH - 1)) ? '0 : pos_r + PW'(1);

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    if (mv12 && taken) begin
      sum_nxt   = sum_r - old_entry + dur;
      count_nxt = count_r + 32'd1;
      pos_nxt   = pos_inc;
    end
  end

  assign ring_wr.en   = mv12 && taken;
  assign ring_wr.addr = pos_r;
  assign ring_wr.data = dur;

  hpma_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (ring_wr),
    .rd_addr  (pos_nxt),
    .rd_value (old_entry)
  );

  assign prod = 65'(sum2_r) * 65'(hpma_pkg::DIV_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notify_enable_r <= 1'b0;
      v1_r            <= 1'b0;
      v2_r            <= 1'b0;
      v3_r            <= 1'b0;
      prev_stamp_r    <= '0;
      pos_r           <= '0;
      sum_r           <= '0;
      count_r         <= '0;
    end else begin
      if (cfg_chan.valid) begin
        notify_enable_r <= cfg_chan.notify_enable;
      end
      if (ready1) v1_r <= in_chan.valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
      if (mv12 && taken) begin
        prev_stamp_r <= stamp1_r;
      end
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_chan.valid) begin
      mask1_r  <= in_chan.pin_mask;
      stamp1_r <= in_chan.timestamp_us;
    end
    if (mv12) begin
      taken2_r  <= taken;
      dur2_r    <= taken ? dur : 32'd0;
      sum2_r    <= sum_nxt;
      count2_r  <= count_nxt;
      notify2_r <= taken && notify_enable_r;
    end
    if (ready3 && v2_r) begin
      taken3_r  <= taken2_r;
      dur3_r    <= dur2_r;
      avg3_r    <= 32'(prod >> (32 + hpma_pkg::DIV_SHIFT));
      count3_r  <= count2_r;
      notify3_r <= notify2_r;
    end
  end

  assign out_chan.valid               = v3_r;
  assign out_chan.edge_taken          = taken3_r;
  assign out_chan.half_period         = dur3_r;
  assign out_chan.average_half_period = avg3_r;
  assign out_chan.edge_total          = count3_r;
  assign out_chan.notify              = notify3_r;

endmodule

// ===== src/hpma_ring.sv =====
// ----------------------------------------------------------------------------
// hpma_ring
// Duration ring with per-entry valid bits and a registered read port that
// presents the entry at rd_addr, forwarding a same-address write.
// ----------------------------------------------------------------------------
module hpma_ring (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hpma_pkg::ring_wr_t        wr,
  input  logic [hpma_pkg::PTR_W-1:0] rd_addr,
  output logic [31:0]               rd_value
);

  logic [31:0]                mem [hpma_pkg::DEPTH];
  logic [hpma_pkg::DEPTH-1:0] valid_r;
  logic [31:0]                rd_data_r;
  logic                       rd_valid_r;
  logic                       byp_r;
  logic [31:0]                byp_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r  <= mem[rd_addr];
    byp_data_r <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
      // write and read of the same entry in one cycle: forward the new data
      byp_r      <= wr.en && (wr.addr == rd_addr);
    end
  end

  // never-written entries read as zero
  assign rd_value = byp_r ? byp_data_r : (rd_valid_r ? rd_data_r : 32'd0);

endmodule
